[sv/hcidf_pkg.sv]
package hcidf_pkg;

  // HCI packet type codes carried on the input tuser
  typedef enum logic [2:0] {
    PT_NONE    = 3'd0,
    PT_COMMAND = 3'd1,
    PT_ACL     = 3'd2,
    PT_SCO     = 3'd3,
    PT_EVENT   = 3'd4,
    PT_ISO     = 3'd5
  } pkt_type_t;

  // Deframer phase, one-hot
  typedef enum logic [1:0] {
    PH_HEADER  = 2'b01,
    PH_PAYLOAD = 2'b10
  } phase_t;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned TypeW  = 3;
  localparam int unsigned LenW   = 2 * ByteW;
  localparam int unsigned HposW  = 3;
  localparam int unsigned HlenW  = 4;
  localparam int unsigned OUserW = TypeW + 3;

  // Header length in bytes; zero marks an invalid type
  function automatic logic [HlenW-1:0] hdr_len(input logic [TypeW-1:0] t);
    logic [HlenW-1:0] r;
    case (t)
      PT_COMMAND: r = 4'd3;
      PT_ACL:     r = 4'd4;
      PT_SCO:     r = 4'd3;
      PT_EVENT:   r = 4'd2;
      PT_ISO:     r = 4'd4;
      default:    r = 4'd0;
    endcase
    return r;
  endfunction

  // Header offset of the (low) payload length byte
  function automatic logic [HposW-1:0] len_pos(input logic [TypeW-1:0] t);
    logic [HposW-1:0] r;
    case (t)
      PT_COMMAND, PT_ACL, PT_SCO, PT_ISO: r = 3'd2;
      PT_EVENT:                           r = 3'd1;
      default:                            r = 3'd0;
    endcase
    return r;
  endfunction

  // Sixteen-bit little-endian length field
  function automatic logic wide_len(input logic [TypeW-1:0] t);
    return (t == PT_ACL) || (t == PT_ISO);
  endfunction

endpackage

[sv/hci_packet_deframer_core.sv]
// HCI H4 packet deframer. Each input transfer carries one stream byte on
// s_axis_tdata and the HCI packet type on s_axis_tuser; the type is sampled
// only at the first header byte of a packet (1 command, 2 ACL, 3 SCO,
// 4 event, 5 ISO). Every byte comes back out with its latched type and the
// first, last and header marks; a packet with a zero length field ends on
// its last header byte. An invalid type at packet start produces one output
// transfer with the error flag set, zero data and marks, and leaves the
// framing state untouched. The block takes one byte per clock: the framing
// update is a small compare and a 16-bit decrement ahead of a single output
// register, and the input stalls only while that register holds a transfer
// the sink has not taken. A byte taken at the input reaches the output in the next cycle.
module hci_packet_deframer_core
  import hcidf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ByteW-1:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [TypeW-1:0]  s_axis_tuser,   // [2:0] hci_type
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [ByteW-1:0]  m_axis_tdata,   // [7:0] out_byte
  output logic              m_axis_tlast,   // last_of_packet
  output logic [OUserW-1:0] m_axis_tuser    // [2:0] out_type, [3] first_of_packet,
                                            // [4] in_header, [5] type_error
);

  // Framing state
  phase_t           phase, phase_next;
  logic [LenW-1:0]  bytes_left, bytes_left_next;
  logic [HposW-1:0] hdr_pos, hdr_pos_next;
  logic [ByteW-1:0] len_lo, len_lo_next;
  logic [TypeW-1:0] ltype, ltype_next;

  // Result fields ahead of the output register
  logic [ByteW-1:0] r_byte;
  logic [TypeW-1:0] r_type;
  logic             r_first, r_last, r_hdr, r_err;

  logic             accept;
  logic [TypeW-1:0] cur_type;
  logic [HlenW-1:0] cur_hlen;
  logic             hdr_end;
  logic [LenW-1:0]  pay_len;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Type in force for this byte: fresh at packet start, latched after
  assign cur_type = (hdr_pos == '0) ? s_axis_tuser : ltype;
  assign cur_hlen = hdr_len(cur_type);
  assign hdr_end  = ({1'b0, hdr_pos} + 4'd1) >= cur_hlen;
  assign pay_len  = wide_len(cur_type) ? {s_axis_tdata, len_lo}
                                       : {{ByteW{1'b0}}, s_axis_tdata};

  // Framing update and result for the byte at the input
  always_comb begin
    phase_next      = phase;
    bytes_left_next = bytes_left;
    hdr_pos_next    = hdr_pos;
    len_lo_next     = len_lo;
    ltype_next      = ltype;
    r_byte          = s_axis_tdata;
    r_type          = ltype;
    r_first         = 1'b0;
    r_last          = 1'b0;
    r_hdr           = 1'b0;
    r_err           = 1'b0;
    unique case (phase)
      PH_HEADER: begin
        if (hdr_pos == '0 && cur_hlen == '0) begin
          // drop the byte and flag the bad type
          r_byte = '0;
          r_type = s_axis_tuser;
          r_err  = 1'b1;
        end else begin
          ltype_next = cur_type;
          r_type     = cur_type;
          r_first    = (hdr_pos == '0);
          r_hdr      = 1'b1;
          if (hdr_pos == len_pos(cur_type)) begin
            len_lo_next = s_axis_tdata;
          end
          if (hdr_end) begin
            hdr_pos_next = '0;
            if (pay_len == '0) begin
              r_last          = 1'b1;
              bytes_left_next = '0;
            end else begin
              phase_next      = PH_PAYLOAD;
              bytes_left_next = pay_len;
            end
          end else begin
            hdr_pos_next = hdr_pos + 3'd1;
          end
        end
      end
      PH_PAYLOAD: begin
        if (bytes_left <= LenW'(1)) begin
          bytes_left_next = '0;
          phase_next      = PH_HEADER;
          hdr_pos_next    = '0;
          r_last          = 1'b1;
        end else begin
          bytes_left_next = bytes_left - LenW'(1);
        end
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase
  end

  // Advance the framing state on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      bytes_left <= '0;
      hdr_pos    <= '0;
      len_lo     <= '0;
      ltype      <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      hdr_pos    <= hdr_pos_next;
      len_lo     <= len_lo_next;
      ltype      <= ltype_next;
    end
  end

  // Output register: load on input transfer, clear valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= r_byte;
      m_axis_tlast <= r_last;
      m_axis_tuser <= {r_err, r_hdr, r_first, r_type};
    end
  end

`ifndef NO_ASSERTIONS
  // An error transfer carries no byte and no framing marks
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[5] |->
      !m_axis_tlast && m_axis_tdata == '0 && m_axis_tuser[4:3] == 2'b00)
    else $error("error transfer carries data or marks");

  // The first byte of a packet is always a header byte
  a_first_hdr: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tuser[4])
    else $error("first byte not marked as header");

  // Payload phase always starts from a rewound header position
  a_pay_pos: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> hdr_pos == '0 && bytes_left != '0)
    else $error("payload phase with stale header position or empty count");

  // No leftover count while framing a header
  a_hdr_cnt: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> bytes_left == '0)
    else $error("byte count left over in header phase");

  // Payload count steps down by one per transfer
  a_pay_dec: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_PAYLOAD && bytes_left > LenW'(1) |=>
      bytes_left == LenW'($past(bytes_left) - LenW'(1)))
    else $error("payload count did not decrement");
`endif

endmodule
